// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level file; they sample on clk_i and are off during rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds at every clock edge
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when cond holds, prop holds at the next clock edge
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/cbt_pkg.sv =====
// Types, constants and helpers of the cubic Bezier tessellator.
`timescale 1ns / 1ps
package cbt_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned T_ONE        = 1 << FRAC_W;
  localparam int unsigned MIN_STEP     = (T_ONE + MAX_SEGMENTS - 1) / MAX_SEGMENTS;
  localparam int unsigned STEP_W       = FRAC_W + 1;
  localparam int unsigned STEP_RESET   = 4096;
  localparam int unsigned T_W          = FRAC_W + 2;
  // point * 2^48 plus cubic terms, all kept modulo 2^64
  localparam int unsigned ACC_W        = 3 * FRAC_W + COORD_W;
  localparam int unsigned DIGIT_W      = 16;
  localparam int unsigned NUM_DIGITS   = ACC_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W  = $clog2(NUM_DIGITS);
  localparam int unsigned C1_W         = 19;
  localparam int unsigned C2_W         = 20;
  localparam int unsigned C3_W         = 19;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned Q_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        ucoord_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic [ACC_W-1:0]          acc_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_a_x;
    coord_t ctrl_a_y;
    coord_t ctrl_b_x;
    coord_t ctrl_b_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t seg_from_x;
    coord_t seg_from_y;
    coord_t seg_to_x;
    coord_t seg_to_y;
    logic   last_segment;
  } out_item_t;

  // power-basis coefficients of one axis, points in offset binary
  typedef struct packed {
    ucoord_t                  p0;
    ucoord_t                  p3;
    logic signed [C1_W-1:0]   c1;
    logic signed [C2_W-1:0]   c2;
    logic signed [C3_W-1:0]   c3;
  } lane_coef_t;

  typedef struct packed {
    lane_coef_t x;
    lane_coef_t y;
    step_t      step;
    logic       direct;
  } job_t;

  function automatic ucoord_t to_offset(coord_t v);
    return {~v[COORD_W-1], v[COORD_W-2:0]};
  endfunction

  function automatic coord_t from_offset(ucoord_t v);
    return {~v[COORD_W-1], v[COORD_W-2:0]};
  endfunction

endpackage

// ===== src/cbt_mul.sv =====
// Digit-serial multiplier: 64-bit operand times the 17-bit step, modulo 2^64.
`timescale 1ns / 1ps
module cbt_mul import cbt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  acc_t  a_i,
  input  step_t b_i,
  output acc_t  prod_o,
  output logic  done_o
);

  logic                       busy_q;
  logic [DIGIT_CNT_W-1:0]     cnt_q;
  acc_t                       opnd_q;
  acc_t                       acc_q;
  acc_t                       acc_d;
  logic [DIGIT_W+STEP_W-1:0]  part;

  assign part   = opnd_q[ACC_W-1 -: DIGIT_W] * b_i;
  assign acc_d  = (acc_q << DIGIT_W) + ACC_W'(part);
  assign done_o = busy_q && (cnt_q == DIGIT_CNT_W'(NUM_DIGITS - 1));
  assign prod_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // most significant digit first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= a_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      opnd_q <= opnd_q << DIGIT_W;
      acc_q  <= acc_d;
    end
  end

endmodule

// ===== src/cbt_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module cbt_queue import cbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/cbt_front.sv =====
// Front end: step register, item intake, coefficient setup and step clamping.
`timescale 1ns / 1ps
module cbt_front import cbt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  step_t    cfg_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output job_t     q_job_o
);

  localparam int unsigned CALC_W = 21;

  step_t step_q;
  step_t step_eff;

  function automatic lane_coef_t make_coef(coord_t a, coord_t b, coord_t c, coord_t d);
    logic signed [CALC_W-1:0] e0;
    logic signed [CALC_W-1:0] e1;
    logic signed [CALC_W-1:0] e2;
    logic signed [CALC_W-1:0] e3;
    logic signed [CALC_W-1:0] s1;
    logic signed [CALC_W-1:0] s2;
    logic signed [CALC_W-1:0] s3;
    lane_coef_t               r;
    e0   = CALC_W'(to_offset(a));
    e1   = CALC_W'(to_offset(b));
    e2   = CALC_W'(to_offset(c));
    e3   = CALC_W'(to_offset(d));
    s1   = e1 - e0;
    s2   = e0 - (e1 <<< 1) + e2;
    s3   = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
    r.p0 = to_offset(a);
    r.p3 = to_offset(d);
    r.c1 = C1_W'(s1 + (s1 <<< 1));
    r.c2 = C2_W'(s2 + (s2 <<< 1));
    r.c3 = C3_W'(s3);
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  always_comb begin
    priority if (step_q < STEP_W'(MIN_STEP)) begin
      step_eff = STEP_W'(MIN_STEP);
    end else if (step_q > STEP_W'(T_ONE)) begin
      step_eff = STEP_W'(T_ONE);
    end else begin
      step_eff = step_q;
    end
  end

  always_comb begin
    q_job_o.x      = make_coef(in_item_i.start_x, in_item_i.ctrl_a_x,
                               in_item_i.ctrl_b_x, in_item_i.end_x);
    q_job_o.y      = make_coef(in_item_i.start_y, in_item_i.ctrl_a_y,
                               in_item_i.ctrl_b_y, in_item_i.end_y);
    q_job_o.step   = step_eff;
    q_job_o.direct = (step_eff == STEP_W'(T_ONE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_W'(STEP_RESET);
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

endmodule

// ===== src/cbt_back.sv =====
// Back end: per-curve multiply setup, forward differencing and segment output.
`timescale 1ns / 1ps
module cbt_back import cbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  job_t      q_job_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FORM_A,
    S_FORM_B,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_C1S,
    OP_C2S,
    OP_C2SS,
    OP_C3S,
    OP_C3SS,
    OP_C3SSS
  } op_e;

  typedef struct packed {
    acc_t    u1;
    acc_t    u2;
    acc_t    u3;
    acc_t    f;
    acc_t    d1;
    acc_t    d2;
    acc_t    d3;
    ucoord_t prev;
  } lane_acc_t;

  state_e           state_q;
  op_e              op_q;
  job_t             job_q;
  lane_acc_t        lx_q;
  lane_acc_t        ly_q;
  logic [T_W-1:0]   t_q;
  logic             out_valid_q;
  out_item_t        out_item_q;

  logic             mul_start;
  acc_t             opnd_x;
  acc_t             opnd_y;
  acc_t             prod_x;
  acc_t             prod_y;
  logic             done_x;
  logic             done_y;
  logic             emit_go;
  logic [T_W-1:0]   t_next;
  logic             is_last;
  lane_acc_t        lx_adv;
  lane_acc_t        ly_adv;
  lane_acc_t        lx_emit;
  lane_acc_t        ly_emit;
  ucoord_t          pt_x;
  ucoord_t          pt_y;

  function automatic acc_t mul_operand(op_e op, lane_coef_t c, lane_acc_t l);
    unique case (op)
      OP_C1S:            return ACC_W'(c.c1);
      OP_C2S:            return ACC_W'(c.c2);
      OP_C2SS:           return l.u2;
      OP_C3S:            return ACC_W'(c.c3);
      OP_C3SS, OP_C3SSS: return l.u3;
      default:           return '0;
    endcase
  endfunction

  function automatic lane_acc_t mul_store(op_e op, lane_acc_t l, acc_t p);
    lane_acc_t r;
    r = l;
    unique case (op)
      OP_C1S:            r.u1 = p;
      OP_C2S, OP_C2SS:   r.u2 = p;
      default:           r.u3 = p;
    endcase
    return r;
  endfunction

  function automatic op_e next_op(op_e op);
    unique case (op)
      OP_C1S:  return OP_C2S;
      OP_C2S:  return OP_C2SS;
      OP_C2SS: return OP_C3S;
      OP_C3S:  return OP_C3SS;
      default: return OP_C3SSS;
    endcase
  endfunction

  // f = p0 * 2^48 + rounding half, d3 = 6 a3, d1 partial
  function automatic lane_acc_t form_a(lane_acc_t l, lane_coef_t c);
    lane_acc_t r;
    r    = l;
    r.f  = (ACC_W'(c.p0) << (3 * FRAC_W)) | (ACC_W'(1'b1) << (3 * FRAC_W - 1));
    r.d3 = (l.u3 << 2) + (l.u3 << 1);
    r.d1 = (l.u1 << (2 * FRAC_W)) + (l.u2 << FRAC_W);
    return r;
  endfunction

  function automatic lane_acc_t form_b(lane_acc_t l);
    lane_acc_t r;
    r    = l;
    r.d2 = (l.u2 << (FRAC_W + 1)) + l.d3;
    r.d1 = l.d1 + l.u3;
    return r;
  endfunction

  function automatic lane_acc_t advance(lane_acc_t l);
    lane_acc_t r;
    r    = l;
    r.f  = l.f + l.d1;
    r.d1 = l.d1 + l.d2;
    r.d2 = l.d2 + l.d3;
    return r;
  endfunction

  assign mul_start = (state_q == S_ISSUE);
  assign opnd_x    = mul_operand(op_q, job_q.x, lx_q);
  assign opnd_y    = mul_operand(op_q, job_q.y, ly_q);

  cbt_mul u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opnd_x),
    .b_i     (job_q.step),
    .prod_o  (prod_x),
    .done_o  (done_x)
  );

  cbt_mul u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opnd_y),
    .b_i     (job_q.step),
    .prod_o  (prod_y),
    .done_o  (done_y)
  );

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign t_next  = t_q + T_W'(job_q.step);
  assign is_last = (t_next >= T_W'(T_ONE));
  assign lx_adv  = advance(lx_q);
  assign ly_adv  = advance(ly_q);
  assign pt_x    = is_last ? job_q.x.p3 : lx_adv.f[3 * FRAC_W +: COORD_W];
  assign pt_y    = is_last ? job_q.y.p3 : ly_adv.f[3 * FRAC_W +: COORD_W];

  always_comb begin
    lx_emit      = lx_adv;
    lx_emit.prev = pt_x;
    ly_emit      = ly_adv;
    ly_emit.prev = pt_y;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_C1S;
      job_q       <= '0;
      lx_q        <= '0;
      ly_q        <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            job_q      <= q_job_i;
            t_q        <= '0;
            op_q       <= OP_C1S;
            lx_q.prev  <= q_job_i.x.p0;
            ly_q.prev  <= q_job_i.y.p0;
            state_q    <= q_job_i.direct ? S_EMIT : S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (done_x && done_y) begin
            lx_q <= mul_store(op_q, lx_q, prod_x);
            ly_q <= mul_store(op_q, ly_q, prod_y);
            if (op_q == OP_C3SSS) begin
              state_q <= S_FORM_A;
            end else begin
              op_q    <= next_op(op_q);
              state_q <= S_ISSUE;
            end
          end
        end
        S_FORM_A: begin
          lx_q    <= form_a(lx_q, job_q.x);
          ly_q    <= form_a(ly_q, job_q.y);
          state_q <= S_FORM_B;
        end
        S_FORM_B: begin
          lx_q    <= form_b(lx_q);
          ly_q    <= form_b(ly_q);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_item_q.seg_from_x   <= from_offset(lx_q.prev);
            out_item_q.seg_from_y   <= from_offset(ly_q.prev);
            out_item_q.seg_to_x     <= from_offset(pt_x);
            out_item_q.seg_to_y     <= from_offset(pt_y);
            out_item_q.last_segment <= is_last;
            lx_q      <= lx_emit;
            ly_q      <= ly_emit;
            t_q       <= t_next;
            if (is_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/cubic_bezier_tessellator_unit.sv =====
// Top level of the cubic Bezier tessellator: front end, job queue and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Each input item is one cubic Bezier curve (start, two control points, end, signed 16-bit
// coordinates); the block returns one line segment per parameter step, from the previous
// point to the next, the final one flagged with last_segment and ending exactly at the end
// point. The step register (cfg_data_i) is a Q1.16 increment, clamped to 1024..65536, so a
// curve yields at most 64 segments. The front end takes a curve whenever the two-entry job
// queue has room. For each curve the back end runs six four-digit 16x17 multiplies per axis
// on its multiplier to set up the forward differences (none when the step is a full unit),
// then emits the segments one after another while the output is not stalled.
module cubic_bezier_tessellator_unit import cbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  step_t     cfg_data_i
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_job_in;
  job_t q_job_out;

  cbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in)
  );

  cbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job_out),
    .empty_o (q_empty)
  );

  cbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_job_i     (q_job_out),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `ASSERT_HOLDS(a_no_pop_empty, !(q_pop && q_empty), "job popped from empty queue")
  `ASSERT_HOLDS(a_no_push_full, !(q_push && q_full), "job pushed into full queue")
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled item changed")

endmodule
